>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Every check is clocked on the rising edge and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that an expression is never true on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hw/rtl/mexp_pkg.sv
package mexp_pkg;

   // Field widths.
   localparam int unsigned MOD_W    = 31;
   localparam int unsigned BASE_W   = 63;
   localparam int unsigned EXP_IN_W = 31;

   // Number of exponent bits that are scanned.
   localparam int unsigned EXP_BITS = 31;

   // The request carries the exponent plus this offset.
   localparam int unsigned EXP_OFFSET = 2;

   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

   localparam int unsigned BIT_CNT_W  = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
   localparam int unsigned STEP_CNT_W = $clog2(BASE_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_LOAD,
      ST_MUL,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Control of the serial modular multipliers.
   typedef struct packed {
      logic load;
      logic step;
   } mm_ctl_type;

endpackage

>>> hw/rtl/mexp_modmul.sv
`include "assert_macros.svh"

// Bit-serial interleaved modular multiplier. A load captures the multiplier and
// clears the partial result; each step consumes one multiplier bit, most
// significant first. The multiplicand and the modulus must hold steady while
// stepping, and the multiplicand must be below the modulus.
module mexp_modmul (
   input  logic                        clock,
   input  logic                        reset,
   input  mexp_pkg::mm_ctl_type        ctl,
   input  logic [mexp_pkg::MOD_W-1:0]  a_in,
   input  logic [mexp_pkg::MOD_W-1:0]  b,
   input  logic [mexp_pkg::MOD_W-1:0]  modulus,
   output logic [mexp_pkg::MOD_W-1:0]  r
);
   import mexp_pkg::*;

   logic [MOD_W-1:0] a_ff, a_in_next;
   logic [MOD_W-1:0] r_ff, r_in;
   logic [MOD_W:0]   dbl;
   logic [MOD_W:0]   dbl_red;
   logic [MOD_W:0]   sum;
   logic [MOD_W:0]   sum_red;
   logic [MOD_W:0]   mod_ext;

   assign mod_ext = {1'b0, modulus};

   always_comb begin
      // Double the partial result and bring it back below the modulus.
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      // Add the multiplicand when the current multiplier bit is set.
      sum     = dbl_red + (a_ff[MOD_W-1] ? {1'b0, b} : '0);
      sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;

      a_in_next = a_ff;
      r_in      = r_ff;
      if (ctl.load) begin
         a_in_next = a_in;
         r_in      = '0;
      end else if (ctl.step) begin
         a_in_next = a_ff << 1;
         r_in      = sum_red[MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in_next;
      r_ff <= r_in;
   end

   assign r = r_ff;

   `ASSERT_CLKD(a_partial_reduced, clock, reset, ctl.step |-> (r_ff < modulus), "modmul partial result not reduced")

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Channel   | Direction | Ports                                            | Meaning
// ----------+-----------+--------------------------------------------------+--------------------
// req       | in        | req_valid, req_ready, req_base_value,            | one request:
//           |           | req_exponent_plus_two                            | base, exponent + 2
// rsp       | out       | rsp_valid, rsp_ready, rsp_power_result           | base^exp mod modulus
// csr       | in        | csr_valid, csr_ready, csr_modulus                | modulus register
//
// A request whose exponent is not positive, or that arrives while the modulus is zero,
// skips the multipliers and goes straight from idle to the done state.
// Any other request first reduces the base one bit at a time, most significant first,
// then for each of the EXP_BITS exponent bits passes through a load state, a multiply phase
// of the two bit-serial modular multipliers and an update state.
// Reset is synchronous and active high; it sets the modulus to 1000000007 and empties the block.
// A new request is accepted as soon as the engine is idle, even while the previous response
// still waits on rsp_ready; the engine only stalls at its end until the output register is free.
`include "assert_macros.svh"

module modular_exponentiation (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mexp_pkg::BASE_W-1:0]    req_base_value,
   input  logic [mexp_pkg::EXP_IN_W-1:0]  req_exponent_plus_two,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mexp_pkg::MOD_W-1:0]     rsp_power_result,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mexp_pkg::MOD_W-1:0]     csr_modulus
);
   import mexp_pkg::*;

   // Control state.
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff;
   logic [MOD_W-1:0]      modulus_ff;

   // Datapath registers.
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [EXP_BITS-1:0]   expo_ff, expo_in;
   logic [MOD_W-1:0]      sq_ff, sq_in;
   logic [MOD_W-1:0]      acc_ff, acc_in;
   logic [STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [MOD_W-1:0]      rsp_power_result_ff;

   // Control outputs of the state machine.
   logic                  rsp_load;
   mm_ctl_type            ctl;

   // Base reduction step and multiplier results.
   logic [MOD_W:0]        red_t;
   logic [MOD_W:0]        red_r;
   logic [MOD_W-1:0]      mul_r;
   logic [MOD_W-1:0]      sqr_r;
   logic                  exp_short;
   logic [EXP_IN_W-1:0]   exp_diff;

   // The effective exponent is at most zero when the request carries 0, 1 or 2.
   assign exp_short = (req_exponent_plus_two <= EXP_IN_W'(EXP_OFFSET));
   assign exp_diff  = req_exponent_plus_two - EXP_IN_W'(EXP_OFFSET);

   // The modulus register can always take a write; writes must only come while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (exp_short || (modulus_ff == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (step_cnt_ff == STEP_CNT_W'(BASE_W - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (step_cnt_ff == STEP_CNT_W'(MOD_W - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (bit_cnt_ff == BIT_CNT_W'(EXP_BITS - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_LOAD:   ctl.load  = 1'b1;
         ST_MUL:    ctl.step  = 1'b1;
         ST_DONE:   rsp_load  = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // One step of the base reduction: shift in the next base bit, most significant first,
   // and subtract the modulus once when the partial remainder reaches it.
   assign red_t = {sq_ff, base_ff[BASE_W-1]};
   assign red_r = (red_t >= {1'b0, modulus_ff}) ? (red_t - {1'b0, modulus_ff}) : red_t;

   // Datapath next values.
   always_comb begin
      base_in     = base_ff;
      expo_in     = expo_ff;
      sq_in       = sq_ff;
      acc_in      = acc_ff;
      step_cnt_in = step_cnt_ff;
      bit_cnt_in  = bit_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            base_in     = req_base_value;
            expo_in     = EXP_BITS'(exp_diff);
            sq_in       = '0;
            step_cnt_in = '0;
            bit_cnt_in  = '0;
            // A zero modulus with a positive exponent has no defined reduction and yields zero.
            if (!exp_short && (modulus_ff == '0)) begin
               acc_in = '0;
            end else begin
               acc_in = MOD_W'(1);
            end
         end
         ST_REDUCE: begin
            sq_in   = red_r[MOD_W-1:0];
            base_in = base_ff << 1;
            if (step_cnt_ff == STEP_CNT_W'(BASE_W - 1)) begin
               step_cnt_in = '0;
            end else begin
               step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
            end
         end
         ST_LOAD: begin
            step_cnt_in = '0;
         end
         ST_MUL: begin
            step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
         end
         ST_UPDATE: begin
            // The square advances every bit; the running product only on a set bit.
            sq_in      = sqr_r;
            if (expo_ff[0]) begin
               acc_in = mul_r;
            end
            expo_in    = expo_ff >> 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Running product times the current square.
   mexp_modmul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .a_in    (acc_ff),
      .b       (sq_ff),
      .modulus (modulus_ff),
      .r       (mul_r)
   );

   // Current square times itself.
   mexp_modmul u_sqr (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .a_in    (sq_ff),
      .b       (sq_ff),
      .modulus (modulus_ff),
      .r       (sqr_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MOD_RESET;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            modulus_ff <= csr_modulus;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      expo_ff     <= expo_in;
      sq_ff       <= sq_in;
      acc_ff      <= acc_in;
      step_cnt_ff <= step_cnt_in;
      bit_cnt_ff  <= bit_cnt_in;
      if (rsp_load) begin
         rsp_power_result_ff <= acc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_power_result_ff;

   `ASSERT_CLKD(a_square_reduced, clock, reset, (state_ff == ST_MUL) |-> (sq_ff < modulus_ff), "square not reduced below the modulus")
   `ASSERT_CLKD(a_accept_busy, clock, reset, (req_valid && req_ready) |=> (state_ff != ST_IDLE), "engine idle after accepting a request")
   `ASSERT_NEVER(a_ctl_excl, clock, reset, ctl.load && ctl.step, "multiplier load and step together")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the modular exponentiation engine. Requests are driven on the
// falling clock edge and the response channel is sampled on the rising edge, so no check
// depends on the order of events within a time step.
module tb_top;

   import mexp_pkg::*;

   logic                  clock;
   logic                  reset;

   logic                  req_valid;
   logic                  req_ready;
   logic [BASE_W-1:0]     req_base_value;
   logic [EXP_IN_W-1:0]   req_exponent_plus_two;

   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [MOD_W-1:0]      rsp_power_result;

   logic                  csr_valid;
   logic                  csr_ready;
   logic [MOD_W-1:0]      csr_modulus;

   // Shadow copy of the modulus register, updated when a write is accepted.
   logic [MOD_W-1:0]      modulus_shadow;

   // Expected power results, oldest at the front, one per accepted request.
   logic [MOD_W-1:0]      expected_power_q[$];
   logic [MOD_W-1:0]      wanted_power;

   int                    mismatch_count;

   // Idle behavior of the two sides, in percent of cycles.
   int                    sender_idle_pct;
   int                    receiver_stall_pct;

   modular_exponentiation DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_base_value        (req_base_value),
      .req_exponent_plus_two (req_exponent_plus_two),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_power_result      (rsp_power_result),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_modulus           (csr_modulus)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A fixed ceiling on the run. The few hundred requests of the run, stalls included, fit
   // many times over in this window.
   initial begin
      #8000000;
      $display("Regression FAIL");
      $finish;
   end

   // Right-to-left square and multiply at the register widths. Every residue is below
   // 2^31, so each product fits in 64 bits before it is reduced.
   function automatic logic [MOD_W-1:0] predict_power(input logic [BASE_W-1:0] base,
                                                      input logic [EXP_IN_W-1:0] e2);
      logic [63:0] m;
      logic [63:0] sq;
      logic [63:0] acc;
      logic [63:0] expo;
      int          i;
      m = 64'(modulus_shadow);
      // A request whose exponent is not positive yields one, even with modulus one.
      if (e2 <= EXP_IN_W'(EXP_OFFSET))
         return MOD_W'(1);
      // With a zero modulus there is no reduction and the result is zero.
      if (m == 64'd0)
         return '0;
      expo = 64'(e2) - 64'(EXP_OFFSET);
      sq   = 64'(base) % m;
      acc  = 64'd1;
      for (i = 0; i < EXP_BITS && i < 63; i++) begin
         if (expo[i])
            acc = (acc * sq) % m;
         sq = (sq * sq) % m;
      end
      return acc[MOD_W-1:0];
   endfunction

   // The receiver stalls at random according to the current phase.
   always @(negedge clock) begin
      if (reset)
         rsp_ready = 1'b0;
      else
         rsp_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_power_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected response: power_result %0d with no request pending",
                        rsp_power_result);
         end else begin
            wanted_power = expected_power_q.pop_front();
            if (rsp_power_result !== wanted_power) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: power_result expected %0d, got %0d",
                           wanted_power, rsp_power_result);
            end
         end
      end
   end

   // Sends one request. The sender may idle first; valid stays high between back-to-back
   // requests, and the payload only changes on a falling edge after acceptance.
   task automatic send_request(input logic [BASE_W-1:0] base, input logic [EXP_IN_W-1:0] e2);
      int gap;
      // Now and then a long gap, so that the request lands at a different point of the
      // previous response's wait on the receiver.
      if (sender_idle_pct != 0 && $urandom_range(0, 49) == 0) begin
         gap = $urandom_range(1, 1200);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid             = 1'b1;
      req_base_value        = base;
      req_exponent_plus_two = e2;
      do @(posedge clock); while (!req_ready);
      expected_power_q.push_back(predict_power(base, e2));
   endtask

   // Lowers valid and waits until every expected response has come back.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_power_q.size() != 0) @(posedge clock);
   endtask

   // Writes the modulus register. It is only called once the engine has drained.
   task automatic write_modulus(input logic [MOD_W-1:0] value);
      @(negedge clock);
      csr_valid   = 1'b1;
      csr_modulus = value;
      do @(posedge clock); while (!csr_ready);
      modulus_shadow = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Exponent edge cases under the modulus left by reset.
   task automatic test_exponent_edge_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(BASE_W'(5), EXP_IN_W'(0));
      send_request({BASE_W{1'b1}}, EXP_IN_W'(1));
      send_request(BASE_W'(7), EXP_IN_W'(2));
      send_request(BASE_W'(0), EXP_IN_W'(3));
      send_request({BASE_W{1'b1}}, EXP_IN_W'(3));
      // An exponent of the prime modulus minus two gives the Fermat inverse of the base.
      send_request(BASE_W'(12345), EXP_IN_W'(1000000007));
      send_request(BASE_W'(1000000006), {EXP_IN_W{1'b1}});
      // A base that is a multiple of the modulus reduces to zero.
      send_request(BASE_W'(64'd1000000007 * 64'd999), EXP_IN_W'(10));
      send_request({BASE_W{1'b1}}, {EXP_IN_W{1'b1}});
      wait_for_responses();
   endtask

   // Extreme moduli: the largest, one, zero and two.
   task automatic test_modulus_extremes();
      write_modulus({MOD_W{1'b1}});
      send_request({BASE_W{1'b1}}, {EXP_IN_W{1'b1}});
      send_request(BASE_W'(3), {MOD_W{1'b1}});
      send_request(BASE_W'(64'h7FFF_FFFE), EXP_IN_W'(4));
      send_request(BASE_W'(2), EXP_IN_W'(2));
      wait_for_responses();

      write_modulus(MOD_W'(1));
      send_request(BASE_W'(9), EXP_IN_W'(0));
      send_request(BASE_W'(9), EXP_IN_W'(3));
      send_request({BASE_W{1'b1}}, {EXP_IN_W{1'b1}});
      wait_for_responses();

      // A zero modulus still answers one for a non-positive exponent.
      write_modulus('0);
      send_request(BASE_W'(9), EXP_IN_W'(2));
      send_request(BASE_W'(9), EXP_IN_W'(3));
      send_request({BASE_W{1'b1}}, {EXP_IN_W{1'b1}});
      wait_for_responses();

      write_modulus(MOD_W'(2));
      send_request(BASE_W'(3), EXP_IN_W'(100));
      send_request(BASE_W'(4), EXP_IN_W'(5));
      wait_for_responses();
   endtask

   // Random requests under one modulus and one idle pattern. Most requests take the full
   // square-and-multiply path; some hit the short path, small exponents or reduced bases.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_count, input logic [MOD_W-1:0] value);
      logic [BASE_W-1:0]   base;
      logic [EXP_IN_W-1:0] e2;
      int                  n;
      write_modulus(value);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (n = 0; n < item_count; n++) begin
         case ($urandom_range(0, 9))
            0:       base = BASE_W'($urandom_range(0, 100));
            1:       base = BASE_W'(64'(modulus_shadow) * 64'($urandom_range(0, 1000)));
            2:       base = {BASE_W{1'b1}} - BASE_W'($urandom_range(0, 3));
            default: base = BASE_W'({$urandom, $urandom});
         endcase
         case ($urandom_range(0, 9))
            0:       e2 = EXP_IN_W'($urandom_range(0, 2));
            1:       e2 = EXP_IN_W'($urandom_range(3, 40));
            2:       e2 = {EXP_IN_W{1'b1}} - EXP_IN_W'($urandom_range(0, 3));
            default: e2 = EXP_IN_W'($urandom);
         endcase
         send_request(base, e2);
         // Occasionally the sender holds back until the engine has drained.
         if ($urandom_range(0, 29) == 0)
            wait_for_responses();
      end
      wait_for_responses();
   endtask

   initial begin
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_base_value        = '0;
      req_exponent_plus_two = '0;
      rsp_ready             = 1'b0;
      csr_valid             = 1'b0;
      csr_modulus           = '0;
      modulus_shadow        = MOD_RESET;
      mismatch_count        = 0;
      sender_idle_pct       = 0;
      receiver_stall_pct    = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_exponent_edge_cases();
      test_modulus_extremes();
      test_random_traffic(0, 0, 68, MOD_W'($urandom) | MOD_W'(1));
      test_random_traffic(57, 0, 68, MOD_W'($urandom_range(2, 1000)));
      test_random_traffic(0, 57, 68, {MOD_W{1'b1}});
      test_random_traffic(25, 25, 68, MOD_W'($urandom));

      wait_for_responses();
      // Let the clock run on so that a stray response would still be seen.
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_power_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
